@@ hdl/bitmap_free_slot_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FREE_SLOT_ALLOCATOR_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define BFSA_ASSERT_SAME(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("allocator check failed");

// Condition in this cycle implies a consequence in the next cycle.
`define BFSA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("allocator check failed");

`endif

@@ hdl/bfsa_pkg.sv @@
`timescale 1ns / 1ps

package bfsa_pkg;

  localparam int WORD_BITS = 32;
  localparam int INDEX_WORD_LIMIT = 128;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_t;

  // One command word.
  typedef struct packed {
    logic        command;
    logic [11:0] slot_index;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [11:0] granted_index;
    status_t     status;
  } result_t;

  // Position of the first clear bit counted from the most significant bit.
  // Only meaningful when the word has at least one clear bit.
  function automatic logic [4:0] first_clear(input logic [31:0] word);
    logic [4:0] pos;
    pos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!word[WORD_BITS - 1 - k]) begin
        pos = 5'(k);
      end
    end
    return pos;
  endfunction

endpackage

@@ hdl/bitmap_free_slot_allocator.sv @@
`timescale 1ns / 1ps
// One command runs at a time; the next one can be accepted at the edge that
// ends the done strobe. A free reads the slot's word, then clears the bit and
// strobes done; an out-of-range free or an allocate with no words in use
// strobes done in the cycle after accept. Allocate reads one bitmap word a cycle
// up to the first word with a clear bit or the last word in use. Reset clears
// all min(MAX_WORDS, 128) stored words with busy high; done cannot be stalled.

module bitmap_free_slot_allocator import bfsa_pkg::*; #(
  parameter int MAX_WORDS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  `include "bitmap_free_slot_allocator_assert.svh"

  // Only words reachable by a 12-bit index are stored.
  localparam int DEPTH = (MAX_WORDS < INDEX_WORD_LIMIT) ? MAX_WORDS : INDEX_WORD_LIMIT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] DEPTH_W = 8'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;

  state_t        state, state_next;
  logic [AW-1:0] cur, cur_next;
  logic [11:0]   slot, slot_next;
  logic [7:0]    active_words;
  logic [7:0]    words;
  result_t       result_next;
  logic          done_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [4:0]    hit_pos;
  logic [31:0]   free_mask;
  logic [6:0]    free_word;

  // Words taking part in scans and frees.
  assign words = (active_words > DEPTH_W) ? DEPTH_W : active_words;

  assign hit_pos   = first_clear(rd_data);
  assign free_mask = 32'h8000_0000 >> slot[4:0];
  assign free_word = cmd.slot_index[11:5];
  assign busy      = (state != S_IDLE);

  // Bitmap memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_words <= 8'd128;
    end else if (cfg_we) begin
      active_words <= cfg_wdata;
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      done  <= done_next;
    end
    slot   <= slot_next;
    result <= result_next;
  end

  // Next state, memory access and result.
  always_comb begin
    state_next  = state;
    cur_next    = cur;
    slot_next   = slot;
    result_next = result;
    done_next   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur;
    mem_wdata   = '0;
    mem_raddr   = cur;
    case (state)
      S_CLEAR: begin
        // Sweep zeros through every word after reset.
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = '0;
        if (cur == LAST_ADDR) begin
          cur_next   = '0;
          state_next = S_IDLE;
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          slot_next = cmd.slot_index;
          if (cmd.command == CMD_ALLOC) begin
            if (words == 8'd0) begin
              result_next.granted_index = '0;
              result_next.status        = ST_FULL;
              done_next                 = 1'b1;
            end else begin
              mem_raddr  = '0;
              cur_next   = '0;
              state_next = S_SCAN;
            end
          end else begin
            if ({1'b0, free_word} >= words) begin
              result_next.granted_index = '0;
              result_next.status        = ST_RANGE;
              done_next                 = 1'b1;
            end else begin
              mem_raddr  = free_word[AW-1:0];
              cur_next   = free_word[AW-1:0];
              state_next = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        // rd_data holds word cur; fetch the next one meanwhile.
        mem_raddr = cur + 1'b1;
        if (rd_data != 32'hFFFF_FFFF) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = rd_data | (32'h8000_0000 >> hit_pos);
          result_next.granted_index = {7'(cur), hit_pos};
          result_next.status        = ST_OK;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if ((8'(cur) + 8'd1) == words) begin
          result_next.granted_index = '0;
          result_next.status        = ST_FULL;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      S_FREE: begin
        // rd_data holds the word of the slot being freed.
        if ((rd_data & free_mask) == 32'd0) begin
          result_next.granted_index = '0;
          result_next.status        = ST_ALREADY;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = rd_data & ~free_mask;
          result_next.granted_index = slot;
          result_next.status        = ST_OK;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result word is only strobed once the block is ready again.
  `BFSA_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // Any error status carries a zero index.
  `BFSA_ASSERT_SAME(a_err_zero, clk, rst, done && (result.status != ST_OK),
    result.granted_index == 12'd0)
  // A free strobes done in the cycle after S_FREE.
  `BFSA_ASSERT_NEXT(a_free_done, clk, rst, state == S_FREE, done)
  // A write-back during a scan always ends the scan.
  `BFSA_ASSERT_NEXT(a_scan_stop, clk, rst, (state == S_SCAN) && mem_we, state == S_IDLE)

endmodule

@@ tb/sv/bitmap_free_slot_allocator_tb.sv @@
`timescale 1ns / 1ps

module bitmap_free_slot_allocator_tb import bfsa_pkg::*;;

  // Tracks the allocation bitmap and the grant words still owed by the block.
  class alloc_tracker;
    logic [31:0] slot_map [INDEX_WORD_LIMIT];
    int unsigned words_now;
    result_t expected_grants[$];
    int errors;

    function new();
      foreach (slot_map[i]) slot_map[i] = '0;
      words_now = INDEX_WORD_LIMIT;
      errors = 0;
    endfunction

    // The register value is capped at the store depth.
    function void set_words(logic [7:0] value);
      words_now = (value > INDEX_WORD_LIMIT) ? INDEX_WORD_LIMIT : value;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // Returns a taken slot inside the words in use, or a random one if none is taken.
    function logic [11:0] pick_taken();
      int span;
      int first;
      int s;
      span = words_now * WORD_BITS;
      if (span == 0) begin
        return 12'($urandom_range(4095, 0));
      end
      first = $urandom_range(span - 1, 0);
      for (int i = 0; i < span; i++) begin
        s = (first + i) % span;
        if (slot_map[s / WORD_BITS][WORD_BITS - 1 - (s % WORD_BITS)]) begin
          return 12'(s);
        end
      end
      return 12'(first);
    endfunction

    // Applies one accepted command word to the bitmap and queues its grant.
    function void apply_command(cmd_t c);
      result_t r;
      bit hit;
      int w;
      int pos;
      r.granted_index = '0;
      r.status = ST_FULL;
      if (c.command == CMD_ALLOC) begin
        hit = 1'b0;
        for (int wi = 0; wi < int'(words_now); wi++) begin
          for (int k = 0; k < WORD_BITS; k++) begin
            if (!hit && !slot_map[wi][WORD_BITS - 1 - k]) begin
              slot_map[wi][WORD_BITS - 1 - k] = 1'b1;
              r.granted_index = 12'(wi * WORD_BITS + k);
              r.status = ST_OK;
              hit = 1'b1;
            end
          end
        end
      end else begin
        w = int'(c.slot_index) / WORD_BITS;
        pos = WORD_BITS - 1 - (int'(c.slot_index) % WORD_BITS);
        if (w >= int'(words_now)) begin
          r.status = ST_RANGE;
        end else if (!slot_map[w][pos]) begin
          r.status = ST_ALREADY;
        end else begin
          slot_map[w][pos] = 1'b0;
          r.granted_index = c.slot_index;
          r.status = ST_OK;
        end
      end
      expected_grants.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one strobed result word with the oldest expectation.
    task check_grant(result_t got);
      result_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d status %0d",
                                  got.granted_index, got.status));
      end else begin
        want = expected_grants.pop_front();
        if (got.granted_index !== want.granted_index) begin
          report_mismatch($sformatf("granted_index %0d, expected %0d",
                                    got.granted_index, want.granted_index));
        end
        if (got.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d (index %0d)",
                                    got.status, want.status, want.granted_index));
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       start;
  cmd_t       cmd;
  logic       busy;
  logic       done;
  result_t    result;

  alloc_tracker book = new();

  bitmap_free_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  always #1 clk = ~clk;

  // Sample accepted command words and strobed results at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        book.check_grant(result);
      end
      if (start && !busy) begin
        book.apply_command(cmd);
      end
    end
  end

  function automatic cmd_t make_cmd(logic op, logic [11:0] slot);
    cmd_t c;
    c.command = op;
    c.slot_index = slot;
    return c;
  endfunction

  // Presents one word and holds it until the block takes it; start stays high.
  task automatic send_word(cmd_t c);
    start = 1'b1;
    cmd = c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Waits until every expected word has come back and the block is idle.
  task automatic drain();
    start = 1'b0;
    while (book.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_words(logic [7:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = value;
    book.set_words(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase: bursts of commands with gaps, allocate share set by alloc_pct.
  task automatic run_phase(logic [7:0] value, int count, int alloc_pct);
    int burst;
    int gap;
    int sel;
    int span;
    cmd_t c;
    write_words(value);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
        if (gap > 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(24, 1);
      end
      span = book.words_now * WORD_BITS;
      if ($urandom_range(99, 0) < alloc_pct) begin
        c = make_cmd(CMD_ALLOC, 12'($urandom_range(4095, 0)));
      end else begin
        sel = $urandom_range(99, 0);
        if (sel < 60) begin
          c = make_cmd(CMD_FREE, book.pick_taken());
        end else if (sel < 75 && span > 0) begin
          c = make_cmd(CMD_FREE, 12'($urandom_range(span - 1, 0)));
        end else begin
          c = make_cmd(CMD_FREE, 12'($urandom_range(4095, 0)));
        end
      end
      send_word(c);
      burst--;
    end
  endtask

  initial begin
    int phase_words [9];
    int phase_items [9];
    int phase_alloc [9];
    phase_words = '{1, 2, 128, 3, 0, 64, 1, 255, 5};
    phase_items = '{70, 90, 120, 60, 15, 80, 40, 100, 40};
    phase_alloc = '{85, 85, 70, 55, 50, 60, 40, 75, 50};
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    cmd = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    drain();

    // Directed: first allocations, double free, free of a clear slot.
    send_word(make_cmd(CMD_ALLOC, 12'd4095));
    send_word(make_cmd(CMD_ALLOC, 12'd0));
    send_word(make_cmd(CMD_ALLOC, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd1));
    send_word(make_cmd(CMD_FREE, 12'd1));
    send_word(make_cmd(CMD_ALLOC, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd4095));
    send_word(make_cmd(CMD_FREE, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd2048));

    // One word in use: frees past it are out of range.
    write_words(8'd1);
    send_word(make_cmd(CMD_FREE, 12'd32));
    send_word(make_cmd(CMD_FREE, 12'd4095));
    send_word(make_cmd(CMD_FREE, 12'd1));
    send_word(make_cmd(CMD_ALLOC, 12'd0));

    // No words in use: allocate is full and every free is out of range.
    write_words(8'd0);
    send_word(make_cmd(CMD_ALLOC, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd4095));

    // A value above the store depth is capped at the full range.
    write_words(8'd255);
    send_word(make_cmd(CMD_FREE, 12'd2));
    send_word(make_cmd(CMD_FREE, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd31));
    send_word(make_cmd(CMD_ALLOC, 12'd0));
    send_word(make_cmd(CMD_FREE, 12'd4095));

    // Random phases move the range up and down so old bits go out and come back.
    for (int p = 0; p < 9; p++) begin
      run_phase(8'(phase_words[p]), phase_items[p], phase_alloc[p]);
    end

    drain();
    repeat (140) @(posedge clk);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
